// ----- hdl/sfcb_pkg.sv -----
// shared types, constants and the prefix-count function for the slot bitmap
// no dependencies
`default_nettype none

package sfcb_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int N_W        = SLOT_W + 1;
  localparam int FILL_W     = 16;
  localparam int CELL_BITS  = 32;
  localparam int CELL_LOG   = $clog2(CELL_BITS);
  localparam int CELL_COUNT = SLOT_COUNT / CELL_BITS;
  localparam int CELL_IDX_W = $clog2(CELL_COUNT);
  localparam int CNT_W      = CELL_LOG + 1;

  localparam logic REQ_FILL  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [SLOT_W-1:0] start_slot;
    logic [SLOT_W-1:0] end_slot;
    logic [FILL_W-1:0] fill_count;
  } in_req_t;

  typedef struct packed {
    logic              placed;
    logic [SLOT_W-1:0] first_slot;
    logic [SLOT_W-1:0] last_slot;
    logic [N_W-1:0]    cleared_count;
  } out_res_t;

  // request token walking along the row of cells
  typedef struct packed {
    logic              valid;
    logic              is_clear;
    logic [SLOT_W-1:0] start_slot;
    logic [SLOT_W-1:0] end_clip;
    logic [N_W-1:0]    n_eff;
    logic [FILL_W-1:0] remaining;
    logic              placed;
    logic [SLOT_W-1:0] first_slot;
    logic [SLOT_W-1:0] last_slot;
    logic [N_W-1:0]    cleared_count;
  } tok_t;

  typedef logic [CELL_BITS-1:0][CNT_W-1:0] pfx_t;

  // inclusive prefix popcount, log-depth
  function automatic pfx_t prefix_count(input logic [CELL_BITS-1:0] v);
    pfx_t p;
    pfx_t nx;
    int   d;
    for (int j = 0; j < CELL_BITS; j++) begin
      p[j] = CNT_W'(v[j]);
    end
    for (int lvl = 0; lvl < CELL_LOG; lvl++) begin
      d = 1 << lvl;
      for (int j = 0; j < CELL_BITS; j++) begin
        if (j >= d) begin
          nx[j] = p[j] + p[j-d];
        end else begin
          nx[j] = p[j];
        end
      end
      p = nx;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/slot_fill_and_clear_bitmap_core.sv -----
// Slot fill-and-clear bitmap allocator, top level.
// depends on sfcb_pkg and sfcb_cell
//
// Usage:
//   in channel (in_valid_i / in_ready_o / in_data_i): one request per transfer,
//   req_type selects fill (search from start_slot for fill_count free slots)
//   or clear (empty start_slot..end_slot and count occupied slots emptied).
//   out channel (out_valid_o / out_ready_i / out_data_o): exactly one result
//   per request, in request order.
//   cfg_we_i / cfg_wdata_i write slots_in_use; only while the block is idle.
// Timing:
//   the map is spread over a row of 32 cells of 32 slots each; a request
//   token steps through one cell per cycle on its way to the output
//   register. One request is in the row at a time: the next transfer is
//   taken only once the result has landed, so a new request is not taken
//   while an earlier one is still in the row.
// Reset:
//   the whole map is empty and slots_in_use reads 1024.
// Stalls:
//   a two-entry result buffer lets one request run while an earlier result
//   waits; with two results waiting in_ready_o stays low.
`default_nettype none

module slot_fill_and_clear_bitmap_core import sfcb_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [N_W-1:0] cfg_wdata_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire in_req_t        in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output out_res_t            out_data_o
);

  logic [N_W-1:0] cfg_q;
  logic [N_W-1:0] n_eff;
  logic           busy_q, busy_d;
  tok_t           tok_q, tok_d;
  tok_t           chain_tok [CELL_COUNT+1];
  logic [CELL_COUNT:0] chain_vld;

  out_res_t out_q, out_d, hold_q, hold_d, res;
  logic     out_valid_q, out_valid_d, hold_valid_q, hold_valid_d;
  logic     in_fire, out_fire, arrive;

  assign n_eff = (cfg_q == '0) ? N_W'(1) :
                 ((cfg_q > N_W'(SLOT_COUNT)) ? N_W'(SLOT_COUNT) : cfg_q);

  assign in_ready_o = !busy_q && !hold_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  always_comb begin
    tok_d       = '0;
    tok_d.valid = 1'b0;
    if (in_fire) begin
      tok_d.valid      = 1'b1;
      tok_d.is_clear   = in_data_i.req_type;
      tok_d.start_slot = in_data_i.start_slot;
      tok_d.end_clip   = ({1'b0, in_data_i.end_slot} >= n_eff) ?
                         SLOT_W'(n_eff - N_W'(1)) : in_data_i.end_slot;
      tok_d.n_eff      = n_eff;
      tok_d.remaining  = (in_data_i.req_type == REQ_FILL) ? in_data_i.fill_count : '0;
    end
  end

  assign chain_tok[0] = tok_q;

  for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
    sfcb_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (CELL_IDX_W'(g)),
      .tok_i      (chain_tok[g]),
      .tok_o      (chain_tok[g+1])
    );
  end

  always_comb begin
    for (int k = 0; k <= CELL_COUNT; k++) begin
      chain_vld[k] = chain_tok[k].valid;
    end
  end

  assign arrive = chain_tok[CELL_COUNT].valid;

  always_comb begin
    res.placed        = chain_tok[CELL_COUNT].placed;
    res.first_slot    = chain_tok[CELL_COUNT].first_slot;
    res.last_slot     = chain_tok[CELL_COUNT].last_slot;
    res.cleared_count = chain_tok[CELL_COUNT].cleared_count;
  end

  always_comb begin
    busy_d       = busy_q;
    out_d        = out_q;
    hold_d       = hold_q;
    out_valid_d  = out_valid_q;
    hold_valid_d = hold_valid_q;
    if (in_fire) busy_d = 1'b1;
    if (arrive)  busy_d = 1'b0;
    if (out_fire) begin
      if (hold_valid_q) begin
        out_d        = hold_q;
        hold_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (arrive) begin
      if (!out_valid_q || (out_fire && !hold_valid_q)) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        hold_d       = res;
        hold_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q        <= N_W'(SLOT_COUNT);
      busy_q       <= 1'b0;
      tok_q        <= '0;
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      busy_q       <= busy_d;
      tok_q        <= tok_d;
      out_valid_q  <= out_valid_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    hold_q <= hold_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chain_vld))
    else $error("more than one request token in the cell row");

  a_token_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arrive |-> busy_q)
    else $error("token reached the row end with no request in flight");

  a_hold_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q |-> out_valid_q)
    else $error("result buffer holds a result behind an empty output");

  a_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (busy_q && tok_q.valid))
    else $error("accepted request did not enter the cell row");

endmodule

`default_nettype wire

// ----- hdl/sfcb_cell.sv -----
// one cell of the row: holds a slice of the occupancy map and serves the passing token
// depends on sfcb_pkg
`default_nettype none

module sfcb_cell import sfcb_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [CELL_IDX_W-1:0] cell_idx_i,
  input  wire tok_t                  tok_i,
  output tok_t                       tok_o
);

  logic [CELL_BITS-1:0] map_q, map_d;
  tok_t                 tok_q, tok_d;

  logic [CELL_BITS-1:0] mask_fill, mask_clear, free_v, hit_v, take_v;
  logic [SLOT_W-1:0]    slot;
  pfx_t                 pfx_free, pfx_hit;
  logic [CNT_W-1:0]     tk;
  logic [CELL_LOG-1:0]  f_idx, l_idx;

  always_comb begin
    for (int j = 0; j < CELL_BITS; j++) begin
      slot          = {cell_idx_i, CELL_LOG'(j)};
      mask_fill[j]  = (slot >= tok_i.start_slot) && ({1'b0, slot} < tok_i.n_eff);
      mask_clear[j] = mask_fill[j] && (slot <= tok_i.end_clip);
    end
    free_v   = ~map_q & mask_fill;
    hit_v    = map_q & mask_clear;
    pfx_free = prefix_count(free_v);
    pfx_hit  = prefix_count(hit_v);
    for (int j = 0; j < CELL_BITS; j++) begin
      take_v[j] = free_v[j] && (FILL_W'(pfx_free[j]) <= tok_i.remaining);
    end
    tk = (tok_i.remaining < FILL_W'(pfx_free[CELL_BITS-1])) ?
         tok_i.remaining[CNT_W-1:0] : pfx_free[CELL_BITS-1];
    f_idx = '0;
    l_idx = '0;
    for (int j = CELL_BITS - 1; j >= 0; j--) begin
      if (take_v[j]) f_idx = CELL_LOG'(j);
    end
    for (int j = 0; j < CELL_BITS; j++) begin
      if (take_v[j]) l_idx = CELL_LOG'(j);
    end
  end

  always_comb begin
    map_d = map_q;
    tok_d = tok_i;
    if (tok_i.valid) begin
      if (tok_i.is_clear == REQ_CLEAR) begin
        map_d               = map_q & ~mask_clear;
        tok_d.cleared_count = tok_i.cleared_count + N_W'(pfx_hit[CELL_BITS-1]);
      end else begin
        map_d           = map_q | take_v;
        tok_d.remaining = tok_i.remaining - FILL_W'(tk);
        if (|take_v) begin
          if (!tok_i.placed) tok_d.first_slot = {cell_idx_i, f_idx};
          tok_d.last_slot = {cell_idx_i, l_idx};
          tok_d.placed    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '0;
      tok_q <= '0;
    end else begin
      map_q <= map_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire
